/* design/vsa_pkg.sv */
package vsa_pkg;

   localparam int TRIG_W        = 16;
   localparam int HOLD_W        = 32;
   localparam int RATE_W        = 19;
   localparam int MODE_W        = 2;
   localparam int GATE_W        = 15;
   localparam int VOICE_INDEX_W = 6;
   localparam int TIME_W        = 64;
   localparam int TICKS_W       = 32;
   localparam int PRODUCT_W     = HOLD_W + RATE_W;
   localparam int FRAC_W        = 16;
   localparam int CSR_INDEX_W   = 8;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_STEAL_MODE  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_RATE = CSR_INDEX_W'(1);

   localparam logic [RATE_W-1:0] SAMPLE_RATE_RESET = RATE_W'(48000);

   typedef enum logic [MODE_W-1:0] {
      STEAL_NONE     = 2'd0,
      STEAL_BY_END   = 2'd1,
      STEAL_BY_START = 2'd2
   } steal_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ALLOC,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] trigger_level;
      logic [HOLD_W-1:0]        hold_seconds;
   } req_payload_type;

   typedef struct packed {
      logic [VOICE_INDEX_W-1:0] voice_index;
      logic [GATE_W-1:0]        gate_level;
      logic                     steal_mark;
      logic                     last_voice;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_payload_type;

   typedef struct packed {
      logic              busy;
      logic [GATE_W-1:0] level;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] end_time;
   } voice_entry_type;

endpackage

/* design/vsa_stream_if.sv */
interface vsa_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* design/vsa_voice_mem.sv */
module vsa_voice_mem #(
   parameter int VOICES = 8,
   localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  vsa_pkg::voice_entry_type wr_entry,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   output vsa_pkg::voice_entry_type rd_entry
);

   vsa_pkg::voice_entry_type mem_ff [VOICES];
   vsa_pkg::voice_entry_type rd_data_ff;
   logic [VOICES-1:0]        valid_ff;
   logic                     rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // entries never written read as an idle voice
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* design/vsa_hold_calc.sv */
module vsa_hold_calc (
   input  logic                         clock,
   input  logic [vsa_pkg::HOLD_W-1:0]   hold_seconds,
   input  logic [vsa_pkg::RATE_W-1:0]   sample_rate,
   output logic [vsa_pkg::TICKS_W-1:0]  ticks
);

   logic [vsa_pkg::PRODUCT_W-1:0] product_ff;
   logic [vsa_pkg::TICKS_W-1:0]   ticks_ff;
   logic [vsa_pkg::TICKS_W-1:0]   ticks_in;
   logic                          overflow;

   assign overflow = |product_ff[vsa_pkg::PRODUCT_W-1:vsa_pkg::FRAC_W+vsa_pkg::TICKS_W];

   // seconds in q16.16 times rate, saturated to 32 bits of ticks
   always_comb begin
      if (overflow) begin
         ticks_in = '1;
      end else begin
         ticks_in = product_ff[vsa_pkg::FRAC_W+vsa_pkg::TICKS_W-1:vsa_pkg::FRAC_W];
      end
   end

   always_ff @(posedge clock) begin
      product_ff <= vsa_pkg::PRODUCT_W'(hold_seconds) * vsa_pkg::PRODUCT_W'(sample_rate);
      ticks_ff   <= ticks_in;
   end

   assign ticks = ticks_ff;

endmodule

/* design/voice_slot_allocator_unit.sv */
// one beat in per sample tick, VOICES beats out, voice 0 first
// a tick walks the voice memory once to retire and search (ST_SCAN), once more to report (ST_OUT),
// one entry per cycle on its read port, the report walk only while the result output is not stalled
// first result beat leaves after the scan, the allocation write in ST_ALLOC and the first report read
// reset is synchronous: all voices read as idle at once, no clearing pass
module voice_slot_allocator_unit #(
   parameter int VOICES = 8
) (
   input  logic          clock,
   input  logic          reset,
   vsa_stream_if.sink    req_bus,
   vsa_stream_if.source  rsp_bus,
   vsa_stream_if.sink    csr_bus
);

   localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CNT_W = $clog2(VOICES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(VOICES - 1);
   localparam logic [CNT_W-1:0] VOICE_CNT  = CNT_W'(VOICES);

   vsa_pkg::state_type        state_ff, state_in;
   vsa_pkg::steal_mode_type   mode_ff;
   logic [vsa_pkg::RATE_W-1:0] rate_ff;

   logic [vsa_pkg::TIME_W-1:0] tick_ff, tick_in;
   logic                       prev_high_ff, prev_high_in;
   logic [IDX_W-1:0]           last_granted_ff, last_granted_in;
   logic                       rise_ff, rise_in;
   logic [vsa_pkg::GATE_W-1:0] level_ff, level_in;
   logic [vsa_pkg::HOLD_W-1:0] hold_ff, hold_in;

   logic [IDX_W-1:0]           rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0]           issue_cnt_ff, issue_cnt_in;
   logic                       rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]           rd_idx_ff, rd_idx_in;

   logic                       found_ff, found_in;
   logic [IDX_W-1:0]           pick_ff, pick_in;
   logic                       best_valid_ff, best_valid_in;
   logic [vsa_pkg::TIME_W-1:0] best_key_ff, best_key_in;
   logic [IDX_W-1:0]           best_idx_ff, best_idx_in;
   logic                       stolen_ff, stolen_in;
   logic [IDX_W-1:0]           stolen_idx_ff, stolen_idx_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   vsa_pkg::rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic                       mem_wr_en;
   logic [IDX_W-1:0]           mem_wr_addr;
   vsa_pkg::voice_entry_type   mem_wr_entry;
   logic                       mem_rd_en;
   vsa_pkg::voice_entry_type   mem_rd_entry;

   logic [vsa_pkg::TICKS_W-1:0] ticks;

   logic                       req_accept;
   logic                       req_high;
   logic [IDX_W-1:0]           rr_start;
   logic                       expired;
   logic                       free_now;
   logic [vsa_pkg::TIME_W-1:0] key;
   logic                       better;
   logic                       steal_on;
   logic                       load;
   logic                       scan_done;

   vsa_voice_mem #(
      .VOICES (VOICES)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (mem_wr_en),
      .wr_addr  (mem_wr_addr),
      .wr_entry (mem_wr_entry),
      .rd_en    (mem_rd_en),
      .rd_addr  (rd_addr_ff),
      .rd_entry (mem_rd_entry)
   );

   vsa_hold_calc u_hold (
      .clock        (clock),
      .hold_seconds (hold_ff),
      .sample_rate  (rate_ff),
      .ticks        (ticks)
   );

   assign req_bus.ready   = (state_ff == vsa_pkg::ST_IDLE);
   assign req_accept      = req_bus.valid && req_bus.ready;
   assign req_high        = (req_bus.payload.trigger_level > 0);
   assign csr_bus.ready   = 1'b1;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

   assign rr_start = (last_granted_ff == LAST_IDX) ? '0 : last_granted_ff + 1'b1;
   assign steal_on = (mode_ff == vsa_pkg::STEAL_BY_END) || (mode_ff == vsa_pkg::STEAL_BY_START);

   // retire check and steal candidate on the entry coming back from memory
   assign expired  = mem_rd_entry.busy && (mem_rd_entry.end_time <= tick_ff);
   assign free_now = !mem_rd_entry.busy || expired;
   assign key      = (mode_ff == vsa_pkg::STEAL_BY_END) ? mem_rd_entry.end_time
                                                        : mem_rd_entry.start_time;
   assign better   = !best_valid_ff || (key < best_key_ff)
                     || ((key == best_key_ff) && (rd_idx_ff < best_idx_ff));
   assign scan_done = rd_pend_ff && (issue_cnt_ff == VOICE_CNT);
   assign load      = rd_pend_ff && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      state_in        = state_ff;
      tick_in         = tick_ff;
      prev_high_in    = prev_high_ff;
      last_granted_in = last_granted_ff;
      rise_in         = rise_ff;
      level_in        = level_ff;
      hold_in         = hold_ff;
      rd_addr_in      = rd_addr_ff;
      issue_cnt_in    = issue_cnt_ff;
      rd_pend_in      = 1'b0;
      rd_idx_in       = rd_idx_ff;
      found_in        = found_ff;
      pick_in         = pick_ff;
      best_valid_in   = best_valid_ff;
      best_key_in     = best_key_ff;
      best_idx_in     = best_idx_ff;
      stolen_in       = stolen_ff;
      stolen_idx_in   = stolen_idx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in     = rsp_data_ff;
      mem_wr_en       = 1'b0;
      mem_wr_addr     = rd_idx_ff;
      mem_wr_entry    = mem_rd_entry;
      mem_rd_en       = 1'b0;

      case (state_ff)
         vsa_pkg::ST_IDLE: begin
            if (req_accept) begin
               tick_in       = tick_ff + 1'b1;
               rise_in       = req_high && !prev_high_ff;
               prev_high_in  = req_high;
               level_in      = req_bus.payload.trigger_level[vsa_pkg::GATE_W-1:0];
               hold_in       = req_bus.payload.hold_seconds;
               stolen_in     = 1'b0;
               found_in      = 1'b0;
               best_valid_in = 1'b0;
               issue_cnt_in  = '0;
               rd_addr_in    = rr_start;
               state_in      = vsa_pkg::ST_SCAN;
            end
         end

         vsa_pkg::ST_SCAN: begin
            // reads go out in round robin order, write-back trails by one entry
            if (issue_cnt_ff != VOICE_CNT) begin
               mem_rd_en    = 1'b1;
               rd_pend_in   = 1'b1;
               rd_idx_in    = rd_addr_ff;
               issue_cnt_in = issue_cnt_ff + 1'b1;
               rd_addr_in   = (rd_addr_ff == LAST_IDX) ? '0 : rd_addr_ff + 1'b1;
            end
            if (rd_pend_ff) begin
               if (expired) begin
                  mem_wr_en          = 1'b1;
                  mem_wr_entry.busy  = 1'b0;
                  mem_wr_entry.level = '0;
               end
               if (free_now && !found_ff) begin
                  found_in = 1'b1;
                  pick_in  = rd_idx_ff;
               end
               if (better) begin
                  best_valid_in = 1'b1;
                  best_key_in   = key;
                  best_idx_in   = rd_idx_ff;
               end
            end
            if (scan_done) begin
               state_in = vsa_pkg::ST_ALLOC;
            end
         end

         vsa_pkg::ST_ALLOC: begin
            mem_wr_entry.busy       = 1'b1;
            mem_wr_entry.level      = level_ff;
            mem_wr_entry.start_time = tick_ff;
            mem_wr_entry.end_time   = tick_ff + vsa_pkg::TIME_W'(ticks);
            if (rise_ff && found_ff) begin
               mem_wr_en       = 1'b1;
               mem_wr_addr     = pick_ff;
               last_granted_in = pick_ff;
            end else if (rise_ff && steal_on) begin
               mem_wr_en     = 1'b1;
               mem_wr_addr   = best_idx_ff;
               stolen_in     = 1'b1;
               stolen_idx_in = best_idx_ff;
            end
            issue_cnt_in = '0;
            rd_addr_in   = '0;
            state_in     = vsa_pkg::ST_OUT;
         end

         vsa_pkg::ST_OUT: begin
            if ((issue_cnt_ff != VOICE_CNT) && (!rd_pend_ff || load)) begin
               mem_rd_en    = 1'b1;
               rd_pend_in   = 1'b1;
               rd_idx_in    = rd_addr_ff;
               issue_cnt_in = issue_cnt_ff + 1'b1;
               rd_addr_in   = (rd_addr_ff == LAST_IDX) ? '0 : rd_addr_ff + 1'b1;
            end else begin
               rd_pend_in = rd_pend_ff && !load;
            end
            if (load) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.voice_index = vsa_pkg::VOICE_INDEX_W'(rd_idx_ff);
               rsp_data_in.gate_level  = mem_rd_entry.level;
               rsp_data_in.steal_mark  = stolen_ff && (stolen_idx_ff == rd_idx_ff);
               rsp_data_in.last_voice  = (rd_idx_ff == LAST_IDX);
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = vsa_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = vsa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vsa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= vsa_pkg::STEAL_NONE;
         rate_ff <= vsa_pkg::SAMPLE_RATE_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.payload.index)
            vsa_pkg::CSR_STEAL_MODE: begin
               mode_ff <= vsa_pkg::steal_mode_type'(csr_bus.payload.data[vsa_pkg::MODE_W-1:0]);
            end
            vsa_pkg::CSR_SAMPLE_RATE: begin
               rate_ff <= csr_bus.payload.data[vsa_pkg::RATE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff         <= '0;
         prev_high_ff    <= 1'b0;
         last_granted_ff <= LAST_IDX;
         rise_ff         <= 1'b0;
         issue_cnt_ff    <= '0;
         rd_pend_ff      <= 1'b0;
         found_ff        <= 1'b0;
         best_valid_ff   <= 1'b0;
         stolen_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         tick_ff         <= tick_in;
         prev_high_ff    <= prev_high_in;
         last_granted_ff <= last_granted_in;
         rise_ff         <= rise_in;
         issue_cnt_ff    <= issue_cnt_in;
         rd_pend_ff      <= rd_pend_in;
         found_ff        <= found_in;
         best_valid_ff   <= best_valid_in;
         stolen_ff       <= stolen_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff      <= level_in;
      hold_ff       <= hold_in;
      rd_addr_ff    <= rd_addr_in;
      rd_idx_ff     <= rd_idx_in;
      pick_ff       <= pick_in;
      best_key_ff   <= best_key_in;
      best_idx_ff   <= best_idx_in;
      stolen_idx_ff <= stolen_idx_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;

   localparam int VOICES = 8;
   localparam logic [vsa_pkg::MODE_W-1:0] STEAL_UNUSED = 2'd3;
   localparam int RUN_LIMIT_NS = 4_000_000;
   localparam int DRAIN_LIMIT = 20000;

   class voice_gate_tracker;
      logic [vsa_pkg::MODE_W-1:0] steal_mode;
      logic [vsa_pkg::RATE_W-1:0] sample_rate;
      logic [vsa_pkg::TIME_W-1:0] tick_count;
      logic                       prev_high;
      int                         last_granted;
      logic                       busy [VOICES];
      logic [vsa_pkg::GATE_W-1:0] level [VOICES];
      logic                       stolen [VOICES];
      logic [vsa_pkg::TIME_W-1:0] start_at [VOICES];
      logic [vsa_pkg::TIME_W-1:0] end_at [VOICES];
      vsa_pkg::rsp_payload_type   expected_gates [$];
      int errors;
      int beats_checked;
      int steals_seen;
      int drops_seen;

      function new();
         steal_mode = vsa_pkg::STEAL_NONE;
         sample_rate = vsa_pkg::SAMPLE_RATE_RESET;
         tick_count = '0;
         prev_high = 1'b0;
         last_granted = VOICES - 1;
         for (int j = 0; j < VOICES; j++) begin
            busy[j] = 1'b0;
            level[j] = '0;
            stolen[j] = 1'b0;
            start_at[j] = '0;
            end_at[j] = '0;
         end
         errors = 0;
         beats_checked = 0;
         steals_seen = 0;
         drops_seen = 0;
      endfunction

      function void write_register(logic [vsa_pkg::CSR_INDEX_W-1:0] index,
                                   logic [vsa_pkg::CSR_DATA_W-1:0] data);
         if (index == vsa_pkg::CSR_STEAL_MODE)
            steal_mode = data[vsa_pkg::MODE_W-1:0];
         else if (index == vsa_pkg::CSR_SAMPLE_RATE)
            sample_rate = data[vsa_pkg::RATE_W-1:0];
      endfunction

      function int claim_voice(output logic took);
         int v;
         int best;
         logic [vsa_pkg::TIME_W-1:0] cand;
         logic [vsa_pkg::TIME_W-1:0] lead;
         took = 1'b0;
         for (int i = 0; i < VOICES; i++) begin
            v = (last_granted + 1 + i) % VOICES;
            if (!busy[v]) begin
               last_granted = v;
               return v;
            end
         end
         if (steal_mode == vsa_pkg::STEAL_BY_END || steal_mode == vsa_pkg::STEAL_BY_START) begin
            best = 0;
            for (int i = 1; i < VOICES; i++) begin
               cand = (steal_mode == vsa_pkg::STEAL_BY_END) ? end_at[i] : start_at[i];
               lead = (steal_mode == vsa_pkg::STEAL_BY_END) ? end_at[best] : start_at[best];
               if (cand < lead)
                  best = i;
            end
            took = 1'b1;
            return best;
         end
         return -1;
      endfunction

      function void note_tick(vsa_pkg::req_payload_type beat);
         logic [vsa_pkg::TRIG_W-1:0] raw;
         logic                       high;
         logic                       took;
         int                         k;
         logic [vsa_pkg::TIME_W-1:0] span;
         vsa_pkg::rsp_payload_type   gate;
         raw = beat.trigger_level;
         high = (raw != '0) && !raw[vsa_pkg::TRIG_W-1];
         tick_count = tick_count + 1;
         for (int j = 0; j < VOICES; j++) begin
            stolen[j] = 1'b0;
            if (busy[j] && end_at[j] <= tick_count) begin
               busy[j] = 1'b0;
               level[j] = '0;
            end
         end
         if (high && !prev_high) begin
            k = claim_voice(took);
            if (k >= 0) begin
               span = (vsa_pkg::TIME_W'(beat.hold_seconds) * vsa_pkg::TIME_W'(sample_rate))
                      >> vsa_pkg::FRAC_W;
               if (span > 64'hFFFF_FFFF)
                  span = 64'hFFFF_FFFF;
               level[k] = raw[vsa_pkg::GATE_W-1:0];
               stolen[k] = took;
               busy[k] = 1'b1;
               start_at[k] = tick_count;
               end_at[k] = tick_count + span;
               if (took)
                  steals_seen++;
            end else begin
               drops_seen++;
            end
         end
         prev_high = high;
         for (int j = 0; j < VOICES; j++) begin
            gate.voice_index = vsa_pkg::VOICE_INDEX_W'(j);
            gate.gate_level = level[j];
            gate.steal_mark = stolen[j];
            gate.last_voice = (j == VOICES - 1);
            expected_gates.push_back(gate);
         end
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("tb: mismatch: %s", what);
      endtask

      task check_gate(vsa_pkg::rsp_payload_type got);
         vsa_pkg::rsp_payload_type want;
         if (expected_gates.size() == 0) begin
            report_mismatch($sformatf("unexpected beat for voice %0d", got.voice_index));
            return;
         end
         want = expected_gates.pop_front();
         beats_checked++;
         if (got.voice_index !== want.voice_index)
            report_mismatch($sformatf("voice_index %0d, want %0d",
                                      got.voice_index, want.voice_index));
         if (got.gate_level !== want.gate_level)
            report_mismatch($sformatf("voice %0d gate_level %0h, want %0h",
                                      want.voice_index, got.gate_level, want.gate_level));
         if (got.steal_mark !== want.steal_mark)
            report_mismatch($sformatf("voice %0d steal_mark %b, want %b",
                                      want.voice_index, got.steal_mark, want.steal_mark));
         if (got.last_voice !== want.last_voice)
            report_mismatch($sformatf("voice %0d last_voice %b, want %b",
                                      want.voice_index, got.last_voice, want.last_voice));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   vsa_stream_if #(.payload_type(vsa_pkg::req_payload_type)) req_if ();
   vsa_stream_if #(.payload_type(vsa_pkg::rsp_payload_type)) rsp_if ();
   vsa_stream_if #(.payload_type(vsa_pkg::csr_payload_type)) csr_if ();

   voice_slot_allocator_unit #(.VOICES(VOICES)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   voice_gate_tracker tracker = new();
   logic idle_on = 1'b1;
   logic level_up = 1'b0;
   int   ticks_sent = 0;
   int   settings_run = 0;

   always #2 clock = ~clock;

   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function logic [vsa_pkg::TRIG_W-1:0] pick_level(logic up);
      int r;
      r = $urandom_range(0, 9);
      if (up) begin
         if (r == 0)
            return 16'h7FFF;
         if (r == 1)
            return 16'h0001;
         return vsa_pkg::TRIG_W'($urandom_range(1, 32767));
      end
      if (r == 0)
         return 16'h0000;
      if (r == 1)
         return 16'h8000;
      if (r == 2)
         return 16'hFFFF;
      return vsa_pkg::TRIG_W'(-int'($urandom_range(1, 32768)));
   endfunction

   // mostly durations of under 25 ticks so voices retire, some zero, long or saturating
   function logic [vsa_pkg::HOLD_W-1:0] pick_hold(logic [vsa_pkg::RATE_W-1:0] rate);
      int r;
      longint unsigned scaled;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         if (rate == '0)
            return $urandom;
         scaled = (longint'($urandom_range(0, 24)) << 16) + $urandom_range(0, 65535);
         return vsa_pkg::HOLD_W'(scaled / rate);
      end
      if (r < 85)
         return $urandom;
      if (r < 93)
         return '0;
      return 32'hFFFF_FFFF;
   endfunction

   task send_tick(logic [vsa_pkg::TRIG_W-1:0] lvl, logic [vsa_pkg::HOLD_W-1:0] hold);
      int gap;
      vsa_pkg::req_payload_type beat;
      beat.trigger_level = lvl;
      beat.hold_seconds = hold;
      gap = gap_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= beat;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      tracker.note_tick(beat);
      ticks_sent++;
   endtask

   task write_csr(logic [vsa_pkg::CSR_INDEX_W-1:0] index,
                  logic [vsa_pkg::CSR_DATA_W-1:0] data);
      vsa_pkg::csr_payload_type beat;
      beat.index = index;
      beat.data = data;
      csr_if.valid <= 1'b1;
      csr_if.payload <= beat;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      tracker.write_register(index, data);
   endtask

   task configure(logic [vsa_pkg::MODE_W-1:0] mode, logic [vsa_pkg::RATE_W-1:0] rate);
      write_csr(vsa_pkg::CSR_STEAL_MODE, vsa_pkg::CSR_DATA_W'(mode));
      write_csr(vsa_pkg::CSR_SAMPLE_RATE, vsa_pkg::CSR_DATA_W'(rate));
      csr_if.valid <= 1'b0;
      settings_run++;
   endtask

   task drain();
      int waited;
      waited = 0;
      req_if.valid <= 1'b0;
      while (tracker.expected_gates.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   task random_phase(logic [vsa_pkg::MODE_W-1:0] mode, logic [vsa_pkg::RATE_W-1:0] rate,
                     int count, logic with_gaps);
      drain();
      configure(mode, rate);
      idle_on = with_gaps;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) < 8)
            level_up = !level_up;
         else
            level_up = $urandom_range(0, 1);
         send_tick(pick_level(level_up), pick_hold(rate));
      end
   endtask

   initial begin
      rsp_if.ready <= 1'b0;
      forever begin : stall_loop
         int stall;
         stall = 0;
         forever begin
            @(posedge clock);
            if (stall > 0) begin
               rsp_if.ready <= 1'b0;
               stall--;
            end else begin
               rsp_if.ready <= 1'b1;
               if ($urandom_range(0, 3) == 0)
                  stall = gap_len();
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         tracker.check_gate(rsp_if.payload);
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("tb: run did not finish in time");
      $display("tb: errors");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      csr_if.valid <= 1'b0;
      csr_if.payload <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero duration, saturated duration, then fill every voice
      send_tick(16'h0000, 32'h0000_0000);
      send_tick(16'h7FFF, 32'h0000_0000);
      send_tick(16'h8000, 32'hFFFF_FFFF);
      send_tick(16'h0001, 32'hFFFF_FFFF);
      send_tick(16'h0064, 32'h0000_0005);
      for (int i = 0; i < VOICES + 1; i++) begin
         send_tick(16'hFFFF, $urandom);
         send_tick(vsa_pkg::TRIG_W'(16'h4000 + i), 32'hFFFF_FFFF);
      end

      random_phase(vsa_pkg::STEAL_BY_END, 19'd1, 55, 1'b1);
      random_phase(vsa_pkg::STEAL_BY_START, 19'd384000, 55, 1'b0);
      random_phase(STEAL_UNUSED, 19'd0, 50, 1'b1);
      random_phase(vsa_pkg::STEAL_BY_END, vsa_pkg::RATE_W'($urandom_range(1, 384000)), 55,
                   1'b1);
      random_phase(vsa_pkg::STEAL_NONE, vsa_pkg::SAMPLE_RATE_RESET, 50, 1'b1);
      random_phase(vsa_pkg::STEAL_BY_START, 19'd1, 55, 1'b1);

      drain();
      repeat (3 * VOICES + 8) @(posedge clock);
      if (tracker.expected_gates.size() != 0)
         tracker.report_mismatch($sformatf("%0d gate beats never arrived",
                                           tracker.expected_gates.size()));

      $display("tb: %0d ticks over %0d register settings, %0d gate beats checked",
               ticks_sent, settings_run, tracker.beats_checked);
      $display("tb: %0d voices stolen, %0d triggers dropped with all voices busy",
               tracker.steals_seen, tracker.drops_seen);
      if (tracker.errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule

/* sim.f */
design/vsa_pkg.sv
design/vsa_stream_if.sv
design/vsa_voice_mem.sv
design/vsa_hold_calc.sv
design/voice_slot_allocator_unit.sv
test/tb.sv
